// ===== hw/rtl/cdts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date and time stepper package
// Beat types, step kind codes and the month length table.
// ----------------------------------------------------------------------------
package cdts_pkg;

  localparam logic [3:0] KIND_SEC_NEXT   = 4'd0;
  localparam logic [3:0] KIND_SEC_PREV   = 4'd1;
  localparam logic [3:0] KIND_MIN_NEXT   = 4'd2;
  localparam logic [3:0] KIND_MIN_PREV   = 4'd3;
  localparam logic [3:0] KIND_HOUR_NEXT  = 4'd4;
  localparam logic [3:0] KIND_HOUR_PREV  = 4'd5;
  localparam logic [3:0] KIND_DAY_NEXT   = 4'd6;
  localparam logic [3:0] KIND_DAY_PREV   = 4'd7;
  localparam logic [3:0] KIND_WEEK_NEXT  = 4'd8;
  localparam logic [3:0] KIND_WEEK_PREV  = 4'd9;
  localparam logic [3:0] KIND_MONTH_NEXT = 4'd10;
  localparam logic [3:0] KIND_MONTH_PREV = 4'd11;

  localparam logic [13:0] YEAR_MAX = 14'd9999;

  // Reciprocal of 25 scaled by 2**17, exact for every 14-bit year.
  localparam logic [12:0] RECIP25 = 13'd5243;

  typedef struct packed {
    logic [3:0]  kind;
    logic [13:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
  } cdts_in_t;

  typedef struct packed {
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic        valid_res;
  } cdts_out_t;

  function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
    logic [4:0] len;
    begin
      len = 5'd0;
      unique case (mo)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
        4'd2: len = leap ? 5'd29 : 5'd28;
        default: len = 5'd0;
      endcase
      return len;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/calendar_date_time_stepper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date and time stepper
// Steps a Gregorian date and time by one second, minute, hour, day, week or
// month, forwards or backwards, in a four-stage pipeline.
//
//   Channel  Direction  Beat type    Handshake
//   in       input      cdts_in_t    in_valid / in_stall
//   out      output     cdts_out_t   out_valid / out_stall
//
// One beat is accepted every cycle while in_stall is low. Stage one holds
// the beat, stage two the year divided by 25 (reciprocal multiply), stage
// three the month lengths, which fold in the leap flag, and the input
// checks, and the output register the stepped result.
// Reset empties every stage. A stall holds the output register and lets
// empty stages ahead of it fill, so in_stall rises only when all are full.
// ----------------------------------------------------------------------------
module calendar_date_time_stepper (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire cdts_pkg::cdts_in_t in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output cdts_pkg::cdts_out_t  out_data
);
  import cdts_pkg::*;

  logic       s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  cdts_in_t   s1_data_r, s2_data_r, s3_data_r;
  cdts_out_t  out_data_r, out_data_nxt;
  logic [9:0] s2_q25_r;
  logic       s3_ok_r;
  logic [4:0] s3_len_r, s3_plen_r;

  logic ld_out, ld3, ld2, ld1;

  logic [26:0] prod25;
  logic [14:0] back25;
  logic        div25, leap;
  logic [3:0]  prev_mo;
  logic [4:0]  len_nxt, plen_nxt;
  logic        ok_nxt;

  assign ld_out   = !out_valid_r || !out_stall;
  assign ld3      = !s3_valid_r || ld_out;
  assign ld2      = !s2_valid_r || ld3;
  assign ld1      = !s1_valid_r || ld2;
  assign in_stall = !ld1;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) begin
        s1_valid_r <= in_valid;
      end
      if (ld2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (ld3) begin
        s3_valid_r <= s2_valid_r;
      end
      if (ld_out) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  assign prod25 = 27'(s1_data_r.in_year) * 27'(RECIP25);

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_data_r <= in_data;
    end
    if (ld2) begin
      s2_data_r <= s1_data_r;
      s2_q25_r  <= prod25[26:17];
    end
    if (ld3) begin
      s3_data_r <= s2_data_r;
      s3_ok_r   <= ok_nxt;
      s3_len_r  <= len_nxt;
      s3_plen_r <= plen_nxt;
    end
    if (ld_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  // A year is leap when divisible by 4 but not 25, or by both 16 and 25.
  always_comb begin
    back25   = {s2_q25_r, 4'd0} + {1'b0, s2_q25_r, 3'd0} + {5'd0, s2_q25_r};
    div25    = (back25 == {1'b0, s2_data_r.in_year});
    leap     = (s2_data_r.in_year[1:0] == 2'd0 && !div25) ||
               (s2_data_r.in_year[3:0] == 4'd0 && div25);
    prev_mo  = (s2_data_r.in_month == 4'd1) ? 4'd12 : s2_data_r.in_month - 4'd1;
    len_nxt  = month_len(s2_data_r.in_month, leap);
    plen_nxt = month_len(prev_mo, leap);
    ok_nxt   = (s2_data_r.kind <= KIND_MONTH_PREV) &&
               (s2_data_r.in_year <= YEAR_MAX) &&
               (s2_data_r.in_month >= 4'd1) && (s2_data_r.in_month <= 4'd12) &&
               (s2_data_r.in_day >= 5'd1) && (s2_data_r.in_day <= len_nxt) &&
               (s2_data_r.in_hour <= 5'd23) &&
               (s2_data_r.in_minute <= 6'd59) &&
               (s2_data_r.in_second <= 6'd59);
  end

  always_comb begin
    logic [3:0]  k;
    logic [13:0] y;
    logic [3:0]  mo;
    logic [4:0]  d, h;
    logic [5:0]  mi, s;
    logic [5:0]  d7;
    logic        inc_s, inc_mi, inc_h, inc_d, inc_mo, inc_y;
    logic        dec_s, dec_mi, dec_h, dec_d, dec_mo, dec_y;
    logic        wk_f, wk_b, wk_f_over, wk_b_under, range_err;
    cdts_out_t   res;
    k  = s3_data_r.kind;
    y  = s3_data_r.in_year;
    mo = s3_data_r.in_month;
    d  = s3_data_r.in_day;
    h  = s3_data_r.in_hour;
    mi = s3_data_r.in_minute;
    s  = s3_data_r.in_second;
    d7 = {1'b0, d} + 6'd7;

    wk_f       = (k == KIND_WEEK_NEXT);
    wk_b       = (k == KIND_WEEK_PREV);
    wk_f_over  = d7 > {1'b0, s3_len_r};
    wk_b_under = d <= 5'd7;

    inc_s  = (k == KIND_SEC_NEXT);
    inc_mi = (k == KIND_MIN_NEXT) || (inc_s && s == 6'd59);
    inc_h  = (k == KIND_HOUR_NEXT) || (inc_mi && mi == 6'd59);
    inc_d  = (k == KIND_DAY_NEXT) || (inc_h && h == 5'd23);
    inc_mo = (k == KIND_MONTH_NEXT) || (inc_d && d == s3_len_r) || (wk_f && wk_f_over);
    inc_y  = inc_mo && mo == 4'd12;

    dec_s  = (k == KIND_SEC_PREV);
    dec_mi = (k == KIND_MIN_PREV) || (dec_s && s == 6'd0);
    dec_h  = (k == KIND_HOUR_PREV) || (dec_mi && mi == 6'd0);
    dec_d  = (k == KIND_DAY_PREV) || (dec_h && h == 5'd0);
    dec_mo = (k == KIND_MONTH_PREV) || (dec_d && d == 5'd1) || (wk_b && wk_b_under);
    dec_y  = dec_mo && mo == 4'd1;

    res.out_second = inc_s ? ((s == 6'd59) ? 6'd0 : s + 6'd1) :
                     dec_s ? ((s == 6'd0) ? 6'd59 : s - 6'd1) : s;
    res.out_minute = inc_mi ? ((mi == 6'd59) ? 6'd0 : mi + 6'd1) :
                     dec_mi ? ((mi == 6'd0) ? 6'd59 : mi - 6'd1) : mi;
    res.out_hour   = inc_h ? ((h == 5'd23) ? 5'd0 : h + 5'd1) :
                     dec_h ? ((h == 5'd0) ? 5'd23 : h - 5'd1) : h;
    if (inc_d) begin
      res.out_day = (d == s3_len_r) ? 5'd1 : d + 5'd1;
    end else if (dec_d) begin
      res.out_day = (d == 5'd1) ? s3_plen_r : d - 5'd1;
    end else if (wk_f) begin
      res.out_day = wk_f_over ? 5'(d7 - {1'b0, s3_len_r}) : d7[4:0];
    end else if (wk_b) begin
      res.out_day = wk_b_under ? 5'({1'b0, d} + {1'b0, s3_plen_r} - 6'd7) : d - 5'd7;
    end else begin
      res.out_day = d;
    end
    res.out_month = inc_mo ? ((mo == 4'd12) ? 4'd1 : mo + 4'd1) :
                    dec_mo ? ((mo == 4'd1) ? 4'd12 : mo - 4'd1) : mo;
    res.out_year  = inc_y ? y + 14'd1 : dec_y ? y - 14'd1 : y;

    range_err = (inc_y && y == YEAR_MAX) || (dec_y && y == 14'd0);
    res.valid_res = 1'b1;

    if (!s3_ok_r || range_err) begin
      out_data_nxt.out_year   = y;
      out_data_nxt.out_month  = mo;
      out_data_nxt.out_day    = d;
      out_data_nxt.out_hour   = h;
      out_data_nxt.out_minute = mi;
      out_data_nxt.out_second = s;
      out_data_nxt.valid_res  = 1'b0;
    end else begin
      out_data_nxt = res;
    end
  end

  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && s3_valid_r && out_valid_r))
    else $error("Input stalled while a pipeline stage is empty.");

  a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.valid_res) |->
      (out_data.out_hour <= 5'd23 && out_data.out_minute <= 6'd59 &&
       out_data.out_second <= 6'd59))
    else $error("Stepped time field out of range.");

  a_date_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.valid_res) |->
      (out_data.out_month >= 4'd1 && out_data.out_month <= 4'd12 &&
       out_data.out_day >= 5'd1 && out_data.out_year <= YEAR_MAX))
    else $error("Stepped date field out of range.");

  a_bubble_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_stall && s3_valid_r) |=> out_valid)
    else $error("Result lost between the last stage and the output register.");

endmodule
`default_nettype wire

// ===== sim/tb_calendar_date_time_stepper.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calendar date and time stepper testbench
// Drives directed and random date/time beats through the stepper under bursty
// input and a patterned output stall. A scoreboard computes every stepped
// date in its own calendar arithmetic and checks each result beat in order.
// ----------------------------------------------------------------------------
module tb_calendar_date_time_stepper;
  import cdts_pkg::*;

  localparam int          RANDOM_ITEMS   = 1500;
  localparam int          SQUEEZE_BEATS  = 48;
  localparam int          SQUEEZE_CYCLES = 300;
  localparam int          TAIL_CYCLES    = 24;
  localparam int          LIMIT_NS       = 2_000_000;
  localparam logic [3:0]  KIND_BAD_LO    = 4'd12;
  localparam logic [3:0]  KIND_BAD_HI    = 4'd15;

  typedef enum {RX_FLOW, RX_RANDOM, RX_COMB, RX_HEAVY} rx_mode_e;

  class date_step_board;
    cdts_out_t due_results[$];
    int        faults;
    int        yr, mon, dy, hr, mn, sc;

    function bit leap_year(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int days_in(int y, int mo);
      if (mo == 2 && leap_year(y)) return 29;
      case (mo)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        2:                     return 28;
        default:               return 0;
      endcase
    endfunction

    function void next_month();
      mon++;
      if (mon > 12) begin
        mon = 1;
        yr++;
      end
    endfunction

    function void prev_month();
      mon--;
      if (mon < 1) begin
        mon = 12;
        yr--;
      end
    endfunction

    function void next_day();
      dy++;
      if (dy > days_in(yr, mon)) begin
        dy = 1;
        next_month();
      end
    endfunction

    function void prev_day();
      dy--;
      if (dy < 1) begin
        prev_month();
        dy = days_in(yr, mon);
      end
    endfunction

    function void next_hour();
      hr++;
      if (hr > 23) begin
        hr = 0;
        next_day();
      end
    endfunction

    function void prev_hour();
      hr--;
      if (hr < 0) begin
        hr = 23;
        prev_day();
      end
    endfunction

    function void next_minute();
      mn++;
      if (mn > 59) begin
        mn = 0;
        next_hour();
      end
    endfunction

    function void prev_minute();
      mn--;
      if (mn < 0) begin
        mn = 59;
        prev_hour();
      end
    endfunction

    function void next_week();
      int len;
      len = days_in(yr, mon);
      dy += 7;
      if (dy > len) begin
        dy -= len;
        next_month();
      end
    endfunction

    function void prev_week();
      dy -= 7;
      if (dy < 1) begin
        prev_month();
        dy += days_in(yr, mon);
      end
    endfunction

    function cdts_out_t step_stamp(cdts_in_t b);
      cdts_out_t r;
      bit        ok;
      yr  = int'(b.in_year);
      mon = int'(b.in_month);
      dy  = int'(b.in_day);
      hr  = int'(b.in_hour);
      mn  = int'(b.in_minute);
      sc  = int'(b.in_second);
      ok = (b.kind <= KIND_MONTH_PREV) && yr <= 9999 && mon >= 1 && mon <= 12 &&
           dy >= 1 && dy <= days_in(yr, mon) && hr <= 23 && mn <= 59 && sc <= 59;
      if (ok) begin
        case (b.kind)
          KIND_SEC_NEXT: begin
            sc++;
            if (sc > 59) begin
              sc = 0;
              next_minute();
            end
          end
          KIND_SEC_PREV: begin
            sc--;
            if (sc < 0) begin
              sc = 59;
              prev_minute();
            end
          end
          KIND_MIN_NEXT:   next_minute();
          KIND_MIN_PREV:   prev_minute();
          KIND_HOUR_NEXT:  next_hour();
          KIND_HOUR_PREV:  prev_hour();
          KIND_DAY_NEXT:   next_day();
          KIND_DAY_PREV:   prev_day();
          KIND_WEEK_NEXT:  next_week();
          KIND_WEEK_PREV:  prev_week();
          KIND_MONTH_NEXT: next_month();
          default:         prev_month();
        endcase
        ok = (yr >= 0) && (yr <= 9999);
      end
      if (ok) begin
        r.out_year   = 14'(yr);
        r.out_month  = 4'(mon);
        r.out_day    = 5'(dy);
        r.out_hour   = 5'(hr);
        r.out_minute = 6'(mn);
        r.out_second = 6'(sc);
        r.valid_res  = 1'b1;
      end else begin
        r.out_year   = b.in_year;
        r.out_month  = b.in_month;
        r.out_day    = b.in_day;
        r.out_hour   = b.in_hour;
        r.out_minute = b.in_minute;
        r.out_second = b.in_second;
        r.valid_res  = 1'b0;
      end
      return r;
    endfunction

    function void note_input(cdts_in_t b);
      due_results.push_back(step_stamp(b));
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        faults++;
      end
    endfunction

    function void check_result(cdts_out_t got);
      cdts_out_t want;
      if (due_results.size() == 0) begin
        $error("result beat arrived with nothing expected");
        faults++;
        return;
      end
      want = due_results.pop_front();
      compare_field("out_year",   int'(want.out_year),   int'(got.out_year));
      compare_field("out_month",  int'(want.out_month),  int'(got.out_month));
      compare_field("out_day",    int'(want.out_day),    int'(got.out_day));
      compare_field("out_hour",   int'(want.out_hour),   int'(got.out_hour));
      compare_field("out_minute", int'(want.out_minute), int'(got.out_minute));
      compare_field("out_second", int'(want.out_second), int'(got.out_second));
      compare_field("valid_res",  int'(want.valid_res),  int'(got.valid_res));
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  cdts_in_t       in_data;
  logic           out_valid;
  logic           out_stall;
  cdts_out_t      out_data;
  bit             squeeze_req;
  date_step_board board;

  calendar_date_time_stepper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_data);
    end
  end

  initial begin : receiver
    rx_mode_e mode;
    int       span;
    int       tick;
    out_stall <= 1'b0;
    tick = 0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(8, 120);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (squeeze_req) begin
          out_stall <= 1'b1;
          repeat (SQUEEZE_CYCLES) @(posedge clk);
          squeeze_req = 1'b0;
        end
        case (mode)
          RX_FLOW:   out_stall <= 1'b0;
          RX_RANDOM: out_stall <= ($urandom_range(0, 99) < 30);
          RX_COMB:   out_stall <= ((tick % 5) < 2);
          default:   out_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  task automatic send_beat(input cdts_in_t b);
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    board.note_input(b);
  endtask

  task automatic send_stamp(input logic [3:0] kind, input int y, input int mo, input int d,
                            input int h, input int mi, input int s);
    cdts_in_t b;
    b.kind      = kind;
    b.in_year   = 14'(y);
    b.in_month  = 4'(mo);
    b.in_day    = 5'(d);
    b.in_hour   = 5'(h);
    b.in_minute = 6'(mi);
    b.in_second = 6'(s);
    send_beat(b);
  endtask

  task automatic pause_sender(input int cycles);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    in_valid <= 1'b0;
    in_data  <= raw[$bits(cdts_in_t)-1:0];
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.due_results.size() != 0);
  endtask

  function automatic int pick_bounded(input int top);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  function automatic cdts_in_t random_stamp();
    cdts_in_t    b;
    logic [63:0] raw;
    int          y, mo, len, d, roll;
    raw  = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      b = raw[$bits(cdts_in_t)-1:0];
      return b;
    end
    case ($urandom_range(0, 4))
      0:       y = $urandom_range(0, 3);
      1:       y = $urandom_range(9996, 9999);
      2:       y = $urandom_range(0, 99) * 100;
      3:       y = $urandom_range(0, 2499) * 4;
      default: y = $urandom_range(0, 9999);
    endcase
    case ($urandom_range(0, 5))
      0:       mo = 2;
      1:       mo = 12;
      2:       mo = 1;
      default: mo = $urandom_range(1, 12);
    endcase
    len = board.days_in(y, mo);
    case ($urandom_range(0, 4))
      0:       d = 1;
      1:       d = len;
      2:       d = len - $urandom_range(0, 6);
      3:       d = 1 + $urandom_range(0, 6);
      default: d = $urandom_range(1, len);
    endcase
    if ($urandom_range(0, 99) < 4) begin
      b.kind = 4'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
    end else begin
      b.kind = 4'($urandom_range(KIND_SEC_NEXT, KIND_MONTH_PREV));
    end
    b.in_year   = 14'(y);
    b.in_month  = 4'(mo);
    b.in_day    = 5'(d);
    b.in_hour   = 5'(pick_bounded(23));
    b.in_minute = 6'(pick_bounded(59));
    b.in_second = 6'(pick_bounded(59));
    if (roll < 15) begin
      case ($urandom_range(0, 5))
        0:       b.in_day    = (len == 31) ? 5'd0 : 5'($urandom_range(len + 1, 31));
        1:       b.in_hour   = 5'($urandom_range(24, 31));
        2:       b.in_minute = 6'($urandom_range(60, 63));
        3:       b.in_second = 6'($urandom_range(60, 63));
        4:       b.in_month  = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
        default: b.in_year   = 14'($urandom_range(10000, 16383));
      endcase
    end
    return b;
  endfunction

  initial begin : stimulus
    int sent;
    int burst;
    bit squeezed;
    board = new;
    squeeze_req = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_stamp(KIND_SEC_NEXT,   9999, 12, 31, 23, 59, 59);
    send_stamp(KIND_SEC_PREV,      0,  1,  1,  0,  0,  0);
    send_stamp(KIND_SEC_NEXT,   2023, 12, 31, 23, 59, 59);
    send_stamp(KIND_SEC_PREV,   2024,  3,  1,  0,  0,  0);
    send_stamp(KIND_MIN_NEXT,   1999, 12, 31, 23, 59, 30);
    send_stamp(KIND_MIN_PREV,   2000,  1,  1,  0,  0, 10);
    send_stamp(KIND_HOUR_NEXT,  1900,  2, 28, 23, 15,  0);
    send_stamp(KIND_HOUR_PREV,  2000,  3,  1,  0,  0,  0);
    send_stamp(KIND_DAY_NEXT,   2000,  2, 28, 12, 30, 30);
    send_stamp(KIND_DAY_PREV,   2100,  3,  1,  6,  7,  8);
    send_stamp(KIND_WEEK_NEXT,  2024,  2, 25,  1,  2,  3);
    send_stamp(KIND_WEEK_PREV,  2023,  3,  3, 22, 58, 57);
    send_stamp(KIND_WEEK_PREV,     0,  1,  5,  0,  0,  0);
    send_stamp(KIND_MONTH_NEXT, 2021,  1, 31, 10, 20, 30);
    send_stamp(KIND_MONTH_PREV,    0,  1, 15,  0,  0,  0);
    send_stamp(KIND_MONTH_NEXT, 9999, 12,  1, 23, 59, 59);
    send_stamp(KIND_MONTH_PREV, 2022,  1, 31,  0,  0,  0);
    send_stamp(KIND_BAD_LO,     2020,  6, 15, 12,  0,  0);
    send_stamp(KIND_BAD_HI,     2020,  6, 15, 12,  0,  0);
    send_stamp(KIND_DAY_NEXT,   1900,  2, 29,  0,  0,  0);
    send_stamp(KIND_DAY_NEXT,   2023,  4, 31,  0,  0,  0);
    send_stamp(KIND_DAY_PREV,   2023,  0,  0,  0,  0,  0);
    send_stamp(KIND_HOUR_NEXT,  2023, 15,  1,  0,  0,  0);
    send_stamp(KIND_SEC_NEXT,   2023,  5, 10, 31, 63, 63);
    send_stamp(KIND_MIN_PREV,  16383,  7,  4,  0,  0,  0);
    wait_for_drain();

    sent = 0;
    squeezed = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (!squeezed && sent >= RANDOM_ITEMS / 3) begin
        // Hold the receiver off while beats keep coming, so the pipeline fills.
        squeezed = 1'b1;
        squeeze_req = 1'b1;
        repeat (SQUEEZE_BEATS) send_beat(random_stamp());
        sent += SQUEEZE_BEATS;
        wait_for_drain();
      end
      burst = $urandom_range(1, 32);
      repeat (burst) send_beat(random_stamp());
      sent += burst;
      if ($urandom_range(0, 3) != 0) begin
        pause_sender($urandom_range(1, 7));
      end
    end

    in_valid <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.faults == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cdts_pkg.sv
hw/rtl/calendar_date_time_stepper.sv
sim/tb_calendar_date_time_stepper.sv
